// ----- src/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// Sortable list engine package
// Word layouts, operation and status codes, and cell control shared by the
// list engine, its cells and its stream interfaces.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam logic [2:0] OP_APPEND  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_DELETE  = 3'd2;
  localparam logic [2:0] OP_REVERSE = 3'd3;
  localparam logic [2:0] OP_SORT    = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_BADPOS = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_BEYOND = 3'd4;

  localparam logic [2:0] M_HOLD    = 3'd0;
  localparam logic [2:0] M_WRITE   = 3'd1;
  localparam logic [2:0] M_INSERT  = 3'd2;
  localparam logic [2:0] M_TAGLOAD = 3'd3;
  localparam logic [2:0] M_SORT    = 3'd4;
  localparam logic [2:0] M_REV     = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [4:0]         position;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [4:0]         list_length;
  } rsp_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               parity;
    logic signed [31:0] wdata;
  } cell_ctrl_t;

endpackage

// ----- src/sle_stream_if.sv -----
// ----------------------------------------------------------------------------
// Sortable list engine stream interface
// Valid/ready channel carrying one word of the given payload type.
// ----------------------------------------------------------------------------
interface sle_stream_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- src/sortable_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Sortable list engine
// Bounded ordered list held in a row of cells, with append, insert, delete,
// reverse, ascending sort and read.
// ----------------------------------------------------------------------------
// Append, insert, delete, read and unused codes: the reply word is
// registered and shown the cycle after the command word is taken.
// Sort and reverse: the command word loads the position tags, the CAPACITY
// odd-even transposition passes then run over the cell row, and the reply
// word is registered after the last pass; no command word is taken meanwhile.
// Reset (synchronous) empties the list and clears the reply valid flag; element
// contents are left as they are and are read only where written.
module sortable_list_engine_unit #(
  parameter int CAPACITY = 16
) (
  input  logic         clk,
  input  logic         rst,
  sle_stream_if.sink   cmd,
  sle_stream_if.source rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                state;
  logic                state_next;
  logic [IW-1:0]       phase;
  logic                rev_run;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                out_valid;
  sle_pkg::rsp_t       out_data;

  sle_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0]       target;
  logic [2:0]          st;
  logic signed [31:0]  rd;
  logic                start_run;
  logic                run_done;
  logic                acc;
  logic                load_out;
  logic [XW-1:0]       pos_x;
  logic [XW-1:0]       cnt_x;

  logic signed [31:0]  vals  [CAPACITY];
  logic [IW-1:0]       tags  [CAPACITY];
  logic                swaps [CAPACITY];

  assign cmd.ready   = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign acc         = cmd.valid && cmd.ready;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  assign pos_x    = XW'(cmd.payload.position);
  assign cnt_x    = XW'(count);
  assign run_done = (state == S_RUN) && (phase == IW'(CAPACITY - 1));
  assign load_out = (acc && !start_run) || run_done;

  always_comb begin
    ctrl.mode   = sle_pkg::M_HOLD;
    ctrl.parity = phase[0];
    ctrl.wdata  = cmd.payload.value;
    target      = '0;
    count_next  = count;
    st          = sle_pkg::ST_OK;
    rd          = '0;
    start_run   = 1'b0;
    state_next  = state;
    if (state == S_RUN) begin
      ctrl.mode = rev_run ? sle_pkg::M_REV : sle_pkg::M_SORT;
      if (run_done) state_next = S_IDLE;
    end else if (acc) begin
      unique case (cmd.payload.op)
        sle_pkg::OP_APPEND: begin
          if (count >= CW'(CAPACITY)) begin
            st = sle_pkg::ST_FULL;
          end else begin
            ctrl.mode  = sle_pkg::M_WRITE;
            target     = IW'(count);
            count_next = count + CW'(1);
          end
        end
        sle_pkg::OP_INSERT: begin
          if (count >= CW'(CAPACITY)) begin
            st = sle_pkg::ST_FULL;
          end else if (count == '0) begin
            ctrl.mode  = sle_pkg::M_INSERT;
            target     = '0;
            count_next = CW'(1);
          end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
            st = sle_pkg::ST_BADPOS;
          end else begin
            ctrl.mode  = sle_pkg::M_INSERT;
            target     = IW'(pos_x - XW'(1));
            count_next = count + CW'(1);
          end
        end
        sle_pkg::OP_DELETE: begin
          if (count == '0) st = sle_pkg::ST_EMPTY;
          else count_next = count - CW'(1);
        end
        sle_pkg::OP_REVERSE, sle_pkg::OP_SORT: begin
          ctrl.mode  = sle_pkg::M_TAGLOAD;
          start_run  = 1'b1;
          state_next = S_RUN;
        end
        sle_pkg::OP_READ: begin
          if (count == '0) begin
            st = sle_pkg::ST_EMPTY;
          end else if (pos_x == '0) begin
            st = sle_pkg::ST_BADPOS;
          end else if (pos_x > cnt_x) begin
            st = sle_pkg::ST_BEYOND;
          end else begin
            rd = vals[IW'(pos_x - XW'(1))];
          end
        end
        default: st = sle_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (start_run || run_done) phase <= '0;
      else if (state == S_RUN) phase <= phase + IW'(1);
      if (load_out) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_run) rev_run <= (cmd.payload.op == sle_pkg::OP_REVERSE);
    if (load_out) begin
      out_data.status      <= st;
      out_data.read_value  <= rd;
      out_data.list_length <= 5'(count_next);
    end
  end

  // Reversal reuses the sorting passes: every cell is tagged with its index
  // and the prefix is then sorted into descending tag order.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lv;
    logic signed [31:0] rv;
    logic [IW-1:0]      lt;
    logic [IW-1:0]      rt;
    logic               si;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lt = '0;
      assign si = 1'b0;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lt = tags[i-1];
      assign si = swaps[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv = '0;
      assign rt = '0;
    end else begin : g_inner
      assign rv = vals[i+1];
      assign rt = tags[i+1];
    end

    sle_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .target    (target),
      .count     (count),
      .left_val  (lv),
      .right_val (rv),
      .left_tag  (lt),
      .right_tag (rt),
      .swap_in   (si),
      .val       (vals[i]),
      .tag       (tags[i]),
      .swap_out  (swaps[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list length beyond capacity");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> !cmd.ready)
    else $error("command word taken during a sort pass");

  a_run_reply: assert property (@(posedge clk) disable iff (rst)
    run_done |=> (out_valid && state == S_IDLE))
    else $error("no reply word after the last sort phase");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && cmd.payload.op == sle_pkg::OP_APPEND && count < CW'(CAPACITY))
      |=> (count == $past(count) + CW'(1)))
    else $error("append did not grow the list");

endmodule

// ----- src/sle_cell.sv -----
// ----------------------------------------------------------------------------
// Sortable list engine cell
// Holds one list element and its position tag, and exchanges them with its
// right-hand neighbour during odd-even transposition passes.
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  logic                 clk,
  input  sle_pkg::cell_ctrl_t  ctrl,
  input  logic [IW-1:0]        target,
  input  logic [CW-1:0]        count,
  input  logic signed [31:0]   left_val,
  input  logic signed [31:0]   right_val,
  input  logic [IW-1:0]        left_tag,
  input  logic [IW-1:0]        right_tag,
  input  logic                 swap_in,
  output logic signed [31:0]   val,
  output logic [IW-1:0]        tag,
  output logic                 swap_out
);

  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [CW:0]   NEXT_IDX = (CW+1)'(IDX + 1);
  localparam logic          ODD      = ((IDX % 2) == 1);

  logic signed [31:0] val_next;
  logic [IW-1:0]      tag_next;
  logic               pair_on;

  // This cell is the left member of an active pair when the phase matches
  // its parity and its neighbour still lies inside the list.
  assign pair_on = (ctrl.parity == ODD) && (NEXT_IDX < {1'b0, count});

  always_comb begin
    swap_out = 1'b0;
    unique case (ctrl.mode)
      sle_pkg::M_SORT: swap_out = pair_on && (val > right_val);
      sle_pkg::M_REV:  swap_out = pair_on && (tag < right_tag);
      default:         swap_out = 1'b0;
    endcase
  end

  always_comb begin
    val_next = val;
    tag_next = tag;
    unique case (ctrl.mode)
      sle_pkg::M_WRITE: begin
        if (MY_IDX == target) val_next = ctrl.wdata;
      end
      sle_pkg::M_INSERT: begin
        if (MY_IDX == target) begin
          val_next = ctrl.wdata;
        end else if (MY_IDX > target) begin
          val_next = left_val;
        end
      end
      sle_pkg::M_TAGLOAD: tag_next = MY_IDX;
      sle_pkg::M_SORT, sle_pkg::M_REV: begin
        if (swap_out) begin
          val_next = right_val;
          tag_next = right_tag;
        end else if (swap_in) begin
          val_next = left_val;
          tag_next = left_tag;
        end
      end
      default: begin
        val_next = val;
        tag_next = tag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    tag <= tag_next;
  end

endmodule

// ----- verif/tb_sortable_list_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sortable list engine testbench
// Drives command words into the list engine and checks every reply word
// against a shadow copy of the list kept here: a short table of hand-picked
// commands first, then random phases that fill, drain and churn the list
// while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sortable_list_engine_unit;

  localparam int CAPACITY  = 16;
  localparam int ITEMS     = 1950;
  localparam int LONG_HOLD = 300;
  localparam int DIRECTED  = 23;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;
  typedef enum int {IDLE_NONE, IDLE_SHORT, IDLE_MIXED} idle_t;

  typedef struct {
    sle_pkg::cmd_t cmd;
    bit            fixed;
    sle_pkg::rsp_t want;
  } table_row_t;

  logic clk;
  logic rst;

  sle_stream_if #(.payload_t(sle_pkg::cmd_t)) cmd_if ();
  sle_stream_if #(.payload_t(sle_pkg::rsp_t)) rsp_if ();

  sortable_list_engine_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .rsp(rsp_if)
  );

  logic signed [31:0] shadow_list[CAPACITY];
  int unsigned        shadow_len;
  sle_pkg::rsp_t      pending_replies[$];
  int                 mismatch_count;
  int                 items_sent;
  idle_t              send_idle;
  idle_t              reply_idle;
  bit                 hold_replies_req;
  table_row_t         directed_rows[DIRECTED];

  // Applies one command to the shadow list and returns the reply it earns.
  function automatic sle_pkg::rsp_t apply_command(sle_pkg::cmd_t c);
    sle_pkg::rsp_t      r;
    int                 k;
    int                 j;
    logic signed [31:0] key;
    logic signed [31:0] tmp;
    r = '0;
    r.status = sle_pkg::ST_OK;
    case (c.op)
      sle_pkg::OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          r.status = sle_pkg::ST_FULL;
        end else begin
          shadow_list[shadow_len] = c.value;
          shadow_len++;
        end
      end
      sle_pkg::OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = sle_pkg::ST_FULL;
        end else if (shadow_len == 0) begin
          shadow_list[0] = c.value;
          shadow_len = 1;
        end else if (c.position == 0 || c.position > shadow_len + 1) begin
          r.status = sle_pkg::ST_BADPOS;
        end else begin
          for (k = shadow_len; k >= c.position; k--) begin
            shadow_list[k] = shadow_list[k-1];
          end
          shadow_list[c.position-1] = c.value;
          shadow_len++;
        end
      end
      sle_pkg::OP_DELETE: begin
        if (shadow_len == 0) begin
          r.status = sle_pkg::ST_EMPTY;
        end else begin
          shadow_len--;
        end
      end
      sle_pkg::OP_REVERSE: begin
        for (j = 0; j < int'(shadow_len / 2); j++) begin
          tmp = shadow_list[j];
          shadow_list[j] = shadow_list[shadow_len-1-j];
          shadow_list[shadow_len-1-j] = tmp;
        end
      end
      sle_pkg::OP_SORT: begin
        for (k = 1; k < int'(shadow_len); k++) begin
          key = shadow_list[k];
          j = k;
          while (j > 0 && shadow_list[j-1] > key) begin
            shadow_list[j] = shadow_list[j-1];
            j--;
          end
          shadow_list[j] = key;
        end
      end
      sle_pkg::OP_READ: begin
        if (shadow_len == 0) begin
          r.status = sle_pkg::ST_EMPTY;
        end else if (c.position == 0) begin
          r.status = sle_pkg::ST_BADPOS;
        end else if (c.position > shadow_len) begin
          r.status = sle_pkg::ST_BEYOND;
        end else begin
          r.read_value = shadow_list[c.position-1];
        end
      end
      default: begin
      end
    endcase
    r.list_length = 5'(shadow_len);
    return r;
  endfunction

  function automatic table_row_t mk_row(logic [2:0] op, logic signed [31:0] value,
                                        logic [4:0] position, bit fixed,
                                        logic [2:0] status, logic signed [31:0] rd,
                                        logic [4:0] len);
    table_row_t t;
    t.cmd.op = op;
    t.cmd.value = value;
    t.cmd.position = position;
    t.fixed = fixed;
    t.want.status = status;
    t.want.read_value = rd;
    t.want.list_length = len;
    return t;
  endfunction

  function automatic int pick_gap(idle_t style);
    int r;
    r = $urandom_range(0, 99);
    case (style)
      IDLE_NONE:  return 0;
      IDLE_SHORT: return (r < 50) ? 0 : $urandom_range(1, 3);
      default: begin
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(8, 40);
      end
    endcase
  endfunction

  function automatic logic [2:0] pick_op(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 60) return sle_pkg::OP_APPEND;
        if (r < 85) return sle_pkg::OP_INSERT;
        if (r < 90) return sle_pkg::OP_READ;
        if (r < 94) return sle_pkg::OP_SORT;
        if (r < 97) return sle_pkg::OP_REVERSE;
        return sle_pkg::OP_DELETE;
      end
      MIX_DRAIN: begin
        if (r < 50) return sle_pkg::OP_DELETE;
        if (r < 70) return sle_pkg::OP_READ;
        if (r < 80) return sle_pkg::OP_INSERT;
        if (r < 85) return sle_pkg::OP_APPEND;
        if (r < 90) return sle_pkg::OP_SORT;
        if (r < 95) return sle_pkg::OP_REVERSE;
        return OP_SPARE_LO;
      end
      default: begin
        if (r < 22) return sle_pkg::OP_APPEND;
        if (r < 40) return sle_pkg::OP_INSERT;
        if (r < 55) return sle_pkg::OP_DELETE;
        if (r < 63) return sle_pkg::OP_REVERSE;
        if (r < 71) return sle_pkg::OP_SORT;
        if (r < 94) return sle_pkg::OP_READ;
        return (r < 97) ? OP_SPARE_LO : OP_SPARE_HI;
      end
    endcase
  endfunction

  // Mostly positions that land inside the list, with zero and wild
  // positions mixed in; values lean on duplicates and the extremes so that
  // sorting has ties and sign boundaries to deal with.
  function automatic sle_pkg::cmd_t next_command(mix_t mix);
    sle_pkg::cmd_t c;
    int            r;
    int            top;
    c.op = pick_op(mix);
    r = $urandom_range(0, 99);
    top = (c.op == sle_pkg::OP_INSERT) ? int'(shadow_len) + 1 : int'(shadow_len);
    if (top < 1) top = 1;
    if (r < 80) c.position = 5'($urandom_range(1, top));
    else if (r < 88) c.position = '0;
    else c.position = 5'($urandom_range(0, 31));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      c.value = $urandom;
    end else if (r < 85) begin
      c.value = 32'($urandom_range(0, 8)) - 32'd4;
    end else begin
      case ($urandom_range(0, 3))
        0:       c.value = 32'sh7FFF_FFFF;
        1:       c.value = 32'sh8000_0000;
        2:       c.value = '0;
        default: c.value = '1;
      endcase
    end
    return c;
  endfunction

  // Offers one word and returns at the edge where it is taken. The valid
  // line is left high when the next word follows without a gap.
  task automatic send_word(sle_pkg::cmd_t c, bit fixed, sle_pkg::rsp_t want);
    sle_pkg::rsp_t predicted;
    int            gap;
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    do @(posedge clk); while (!cmd_if.ready);
    predicted = apply_command(c);
    pending_replies.push_back(fixed ? want : predicted);
    items_sent++;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      cmd_if.valid   <= 1'b0;
      cmd_if.payload <= sle_pkg::cmd_t'(40'({$urandom, $urandom}));
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (mismatch_count < 10) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
    end
    mismatch_count++;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // Reply checker.
  always @(posedge clk) begin
    sle_pkg::rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        note_mismatch("unexpected reply word", '0, {29'd0, rsp_if.payload.status});
      end else begin
        want = pending_replies.pop_front();
        if (rsp_if.payload.status !== want.status)
          note_mismatch("status", 32'(want.status), 32'(rsp_if.payload.status));
        if (rsp_if.payload.read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, rsp_if.payload.read_value);
        if (rsp_if.payload.list_length !== want.list_length)
          note_mismatch("list_length", 32'(want.list_length),
                        32'(rsp_if.payload.list_length));
      end
    end
  end

  // Reply side: bursts of ready, stalls of random length, and a long hold
  // whenever the command side asks for one.
  initial begin
    int n;
    int m;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_replies_req) begin
        hold_replies_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = (reply_idle == IDLE_NONE) ? $urandom_range(16, 64) : $urandom_range(1, 8);
        rsp_if.ready <= 1'b1;
        repeat (n) @(posedge clk);
        m = pick_gap(reply_idle);
        if (m > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (m) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int   phase;
    int   count;
    mix_t mix;
    rst              <= 1'b1;
    cmd_if.valid     <= 1'b0;
    cmd_if.payload   <= '0;
    mismatch_count   = 0;
    items_sent       = 0;
    shadow_len       = 0;
    hold_replies_req = 1'b0;
    send_idle        = IDLE_SHORT;
    reply_idle       = IDLE_SHORT;

    directed_rows = '{
      mk_row(sle_pkg::OP_READ,    32'sd0,         5'd1, 1, sle_pkg::ST_EMPTY,  32'sd0, 5'd0),
      mk_row(sle_pkg::OP_DELETE,  32'sd0,         5'd0, 1, sle_pkg::ST_EMPTY,  32'sd0, 5'd0),
      mk_row(sle_pkg::OP_REVERSE, 32'sd0,         5'd0, 1, sle_pkg::ST_OK,     32'sd0, 5'd0),
      mk_row(sle_pkg::OP_SORT,    32'sd0,         5'd0, 1, sle_pkg::ST_OK,     32'sd0, 5'd0),
      mk_row(sle_pkg::OP_INSERT,  32'sh7FFF_FFFF, 5'd0, 1, sle_pkg::ST_OK,     32'sd0, 5'd1),
      mk_row(sle_pkg::OP_REVERSE, 32'sd0,         5'd0, 1, sle_pkg::ST_OK,     32'sd0, 5'd1),
      mk_row(sle_pkg::OP_SORT,    32'sd0,         5'd0, 1, sle_pkg::ST_OK,     32'sd0, 5'd1),
      mk_row(sle_pkg::OP_READ,    32'sd0,         5'd0, 1, sle_pkg::ST_BADPOS, 32'sd0, 5'd1),
      mk_row(sle_pkg::OP_READ,    32'sd0,         5'd2, 1, sle_pkg::ST_BEYOND, 32'sd0, 5'd1),
      mk_row(sle_pkg::OP_READ, 32'sd0, 5'd1, 1, sle_pkg::ST_OK, 32'sh7FFF_FFFF, 5'd1),
      mk_row(sle_pkg::OP_APPEND,  32'sh8000_0000, 5'd0, 1, sle_pkg::ST_OK,     32'sd0, 5'd2),
      mk_row(sle_pkg::OP_INSERT,  32'sd5,         5'd0, 1, sle_pkg::ST_BADPOS, 32'sd0, 5'd2),
      mk_row(sle_pkg::OP_INSERT,  32'sd5,         5'd4, 1, sle_pkg::ST_BADPOS, 32'sd0, 5'd2),
      mk_row(sle_pkg::OP_INSERT,  -32'sd1,        5'd3, 1, sle_pkg::ST_OK,     32'sd0, 5'd3),
      mk_row(sle_pkg::OP_INSERT,  32'sd0,         5'd1, 1, sle_pkg::ST_OK,     32'sd0, 5'd4),
      mk_row(sle_pkg::OP_SORT,    32'sd0,         5'd0, 0, sle_pkg::ST_OK,     32'sd0, 5'd0),
      mk_row(sle_pkg::OP_READ,    32'sd0,         5'd1, 0, sle_pkg::ST_OK,     32'sd0, 5'd0),
      mk_row(sle_pkg::OP_REVERSE, 32'sd0,         5'd0, 0, sle_pkg::ST_OK,     32'sd0, 5'd0),
      mk_row(sle_pkg::OP_READ,    32'sd0,         5'd4, 0, sle_pkg::ST_OK,     32'sd0, 5'd0),
      mk_row(sle_pkg::OP_READ,    32'sd0,        5'd31, 1, sle_pkg::ST_BEYOND, 32'sd0, 5'd4),
      mk_row(OP_SPARE_LO,         -32'sd1,       5'd31, 1, sle_pkg::ST_OK,     32'sd0, 5'd4),
      mk_row(OP_SPARE_HI,         32'sh5555_AAAA, 5'd21, 1, sle_pkg::ST_OK,    32'sd0, 5'd4),
      mk_row(sle_pkg::OP_DELETE,  32'sd0,         5'd0, 1, sle_pkg::ST_OK,     32'sd0, 5'd3)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].want);
    end

    phase = 0;
    while (items_sent < ITEMS) begin
      mix        = (phase == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      send_idle  = idle_t'($urandom_range(0, 2));
      reply_idle = idle_t'($urandom_range(0, 2));
      // Hold the reply side off while words keep coming, so the engine
      // fills up and pushes back on its command input.
      if (phase == 2 || phase == 9) begin
        hold_replies_req = 1'b1;
        send_idle = IDLE_NONE;
      end
      // Let the engine drain completely before carrying on.
      if (phase == 5 || phase == 12) begin
        cmd_if.valid <= 1'b0;
        wait (pending_replies.size() == 0);
        @(posedge clk);
      end
      count = $urandom_range(40, 120);
      repeat (count) begin
        send_word(next_command(mix), 1'b0, '0);
      end
      phase++;
    end

    cmd_if.valid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (3 * CAPACITY) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
